[hw/rtl/lrp_pkg.sv]
// Shared types, constants and helpers for the lidar range-to-point block.
package lrp_pkg;

	localparam int RANGE_W    = 24;
	localparam int STR_W      = 16;
	localparam int COL_W      = 12;
	localparam int RING_W     = 7;
	localparam int COORD_W    = 25;
	localparam int TIME_W     = 32;
	localparam int TSTEP_W    = 20;
	localparam int ANG_CFG_W  = 16;
	localparam int RCOUNT_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int TURN_W     = 32;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 136;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 24;
	localparam int CW           = 34;
	localparam int TRIG_W       = 32;
	localparam int H_W          = 27;
	localparam int XY_W         = 29;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = 2;

	localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;
	localparam logic signed [CW-1:0] ROUND_HALF   = 34'sd536870912;

	localparam logic signed [CW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81
	};

	localparam logic signed [XY_W-1:0] COORD_MAX = 29'sd16777215;
	localparam logic signed [XY_W-1:0] COORD_MIN = -29'sd16777216;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_LO    = 3'd0,
		REG_RANGE_HI    = 3'd1,
		REG_YAW_START   = 3'd2,
		REG_YAW_STEP    = 3'd3,
		REG_PITCH_START = 3'd4,
		REG_PITCH_STEP  = 3'd5,
		REG_RING_COUNT  = 3'd6,
		REG_TIME_STEP   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [RANGE_W-1:0]          range_lo;
		logic [RANGE_W-1:0]          range_hi;
		logic signed [ANG_CFG_W-1:0] yaw_start;
		logic signed [ANG_CFG_W-1:0] yaw_step;
		logic signed [ANG_CFG_W-1:0] pitch_start;
		logic signed [ANG_CFG_W-1:0] pitch_step;
		logic [RCOUNT_W-1:0]         ring_count;
		logic [TSTEP_W-1:0]          time_step;
	} cfg_t;

	// item handed from the front to the back through the queue
	typedef struct packed {
		logic [RANGE_W-1:0]       range_value;
		logic [STR_W-1:0]         strength;
		logic [RING_W-1:0]        ring_number;
		logic [TIME_W-1:0]        offset_time;
		logic signed [TURN_W-1:0] yaw_turn;
		logic signed [TURN_W-1:0] pitch_turn;
	} job_t;

	// payload riding along the CORDIC stages
	typedef struct packed {
		logic [RANGE_W-1:0] range_value;
		logic [STR_W-1:0]   strength;
		logic [RING_W-1:0]  ring_number;
		logic [TIME_W-1:0]  offset_time;
		logic               neg_yaw;
		logic               neg_pitch;
	} carry_t;

	// clamp a coordinate to the output range
	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [XY_W-1:0] v);
		logic signed [XY_W-1:0] c;
		c = v;
		if (v > COORD_MAX) c = COORD_MAX;
		if (v < COORD_MIN) c = COORD_MIN;
		return c[COORD_W-1:0];
	endfunction

endpackage

[hw/rtl/lrp_front.sv]
// Front part: gates returns, forms binary angles, ring number and time offset.
module lrp_front #(
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_RINGS   = 128,
	parameter int ANGLE_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lrp_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lrp_pkg::RANGE_W-1:0]  range_value,
	input  logic [lrp_pkg::STR_W-1:0]    echo_strength,
	input  logic [lrp_pkg::COL_W-1:0]    column_index,
	input  logic [lrp_pkg::RING_W-1:0]   ring_index,
	output logic                         job_valid,
	input  logic                         job_ready,
	output lrp_pkg::job_t                job
);
	import lrp_pkg::*;

	localparam int CNT_W  = ($clog2(MAX_RINGS + 1) > RCOUNT_W) ? $clog2(MAX_RINGS + 1) : RCOUNT_W;
	localparam int COLC_W = ($clog2(MAX_COLUMNS + 1) > COL_W) ? $clog2(MAX_COLUMNS + 1)
		: COL_W + 1;
	localparam int PAD_W  = TURN_W - ANGLE_BITS;

	logic [CNT_W-1:0]         count;
	logic [CNT_W-1:0]         rc_ext;
	logic                     keep;
	logic signed [TURN_W-1:0] col_s;
	logic signed [TURN_W-1:0] ring_s;
	logic signed [TURN_W-1:0] yaw_full;
	logic signed [TURN_W-1:0] pitch_full;
	job_t                     job_d;
	logic                     v_s1;
	job_t                     job_s1;

	// classify the return and build its job
	always_comb begin
		rc_ext = CNT_W'(cfg.ring_count);
		count  = (rc_ext > CNT_W'(MAX_RINGS)) ? CNT_W'(MAX_RINGS) : rc_ext;
		keep   = (cfg.range_lo < range_value) && (range_value < cfg.range_hi)
			&& (CNT_W'(ring_index) < count)
			&& (COLC_W'(column_index) < COLC_W'(MAX_COLUMNS));
		col_s      = TURN_W'(column_index);
		ring_s     = TURN_W'(ring_index);
		yaw_full   = TURN_W'(cfg.yaw_start) + col_s * TURN_W'(cfg.yaw_step);
		pitch_full = TURN_W'(cfg.pitch_start) + ring_s * TURN_W'(cfg.pitch_step);
		job_d.range_value = range_value;
		job_d.strength    = echo_strength;
		job_d.ring_number = RING_W'(count - CNT_W'(1) - CNT_W'(ring_index));
		job_d.offset_time = TIME_W'(TIME_W'(column_index) * TIME_W'(cfg.time_step));
		job_d.yaw_turn    = {yaw_full[ANGLE_BITS-1:0], {PAD_W{1'b0}}};
		job_d.pitch_turn  = {pitch_full[ANGLE_BITS-1:0], {PAD_W{1'b0}}};
	end

	assign in_ready  = !v_s1 || job_ready;
	assign job_valid = v_s1;
	assign job       = job_s1;

	// hold or advance the front stage; drop returns that give no point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_s1 <= job_d;
		end
	end

endmodule

[hw/rtl/lrp_fifo.sv]
// Short job queue between the front and the back.
module lrp_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  lrp_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_ready,
	output lrp_pkg::job_t rd_job
);
	import lrp_pkg::*;

	job_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign wr_ready = count_q != (QPTR_W + 1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_job   = mem[rd_ptr_q];

	// track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)      count_q <= count_q + (QPTR_W + 1)'(1);
			else if (pop && !push) count_q <= count_q - (QPTR_W + 1)'(1);
		end
	end

	// store an incoming item
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

endmodule

[hw/rtl/lrp_back.sv]
// Back part: two pipelined CORDICs, scaling multiplies and the output register.
module lrp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lrp_pkg::job_t                     job,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lrp_pkg::COORD_W-1:0]       point_x,
	output logic [lrp_pkg::COORD_W-1:0]       point_y,
	output logic [lrp_pkg::COORD_W-1:0]       point_z,
	output logic [lrp_pkg::STR_W-1:0]         point_strength,
	output logic [lrp_pkg::RING_W-1:0]        ring_number,
	output logic [lrp_pkg::TIME_W-1:0]        offset_time
);
	import lrp_pkg::*;

	logic                  adv;
	logic signed [CW-1:0]  yt0;
	logic signed [CW-1:0]  pt0;
	logic                  yneg0;
	logic                  pneg0;

	logic                  v_c  [CORDIC_STEPS+1];
	carry_t                cr_c [CORDIC_STEPS+1];
	logic signed [CW-1:0]  yx_c [CORDIC_STEPS+1];
	logic signed [CW-1:0]  yy_c [CORDIC_STEPS+1];
	logic signed [CW-1:0]  yt_c [CORDIC_STEPS+1];
	logic signed [CW-1:0]  px_c [CORDIC_STEPS+1];
	logic signed [CW-1:0]  py_c [CORDIC_STEPS+1];
	logic signed [CW-1:0]  pt_c [CORDIC_STEPS+1];

	logic                      v_s1, v_s2, v_s3, out_valid_q;
	carry_t                    cr_s1, cr_s2, cr_s3;
	logic signed [TRIG_W-1:0]  cy_s1, sy_s1, cp_s1, sp_s1;
	logic signed [TRIG_W-1:0]  cy_s2, sy_s2;
	logic signed [H_W-1:0]     h_s2, z_s2, z_s3;
	logic signed [XY_W-1:0]    x_s3, y_s3;
	logic signed [56:0]        hp_prod, zp_prod;
	logic signed [58:0]        xp_prod, yp_prod;
	logic [COORD_W-1:0]        x_q, y_q, z_q;
	logic [STR_W-1:0]          str_q;
	logic [RING_W-1:0]         ring_q;
	logic [TIME_W-1:0]         time_q;

	// whole back pipeline moves when the output register can take an item
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// fold angles beyond a quarter turn back by a half turn
	always_comb begin
		yt0   = CW'(job.yaw_turn);
		pt0   = CW'(job.pitch_turn);
		yneg0 = 1'b0;
		pneg0 = 1'b0;
		if (yt0 > QUARTER_TURN) begin
			yt0 = yt0 - HALF_TURN; yneg0 = 1'b1;
		end else if (yt0 < -QUARTER_TURN) begin
			yt0 = yt0 + HALF_TURN; yneg0 = 1'b1;
		end
		if (pt0 > QUARTER_TURN) begin
			pt0 = pt0 - HALF_TURN; pneg0 = 1'b1;
		end else if (pt0 < -QUARTER_TURN) begin
			pt0 = pt0 + HALF_TURN; pneg0 = 1'b1;
		end
	end

	// load the first CORDIC stage
	always_ff @(posedge clk) begin
		if (adv) begin
			cr_c[0].range_value <= job.range_value;
			cr_c[0].strength    <= job.strength;
			cr_c[0].ring_number <= job.ring_number;
			cr_c[0].offset_time <= job.offset_time;
			cr_c[0].neg_yaw     <= yneg0;
			cr_c[0].neg_pitch   <= pneg0;
			yx_c[0] <= CORDIC_GAIN;
			yy_c[0] <= '0;
			yt_c[0] <= yt0;
			px_c[0] <= CORDIC_GAIN;
			py_c[0] <= '0;
			pt_c[0] <= pt0;
		end
	end

	// one micro-rotation per stage for both angles
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (adv) begin
				cr_c[i+1] <= cr_c[i];
				if (!yt_c[i][CW-1]) begin
					yx_c[i+1] <= yx_c[i] - (yy_c[i] >>> i);
					yy_c[i+1] <= yy_c[i] + (yx_c[i] >>> i);
					yt_c[i+1] <= yt_c[i] - ATAN_TURN[i];
				end else begin
					yx_c[i+1] <= yx_c[i] + (yy_c[i] >>> i);
					yy_c[i+1] <= yy_c[i] - (yx_c[i] >>> i);
					yt_c[i+1] <= yt_c[i] + ATAN_TURN[i];
				end
				if (!pt_c[i][CW-1]) begin
					px_c[i+1] <= px_c[i] - (py_c[i] >>> i);
					py_c[i+1] <= py_c[i] + (px_c[i] >>> i);
					pt_c[i+1] <= pt_c[i] - ATAN_TURN[i];
				end else begin
					px_c[i+1] <= px_c[i] + (py_c[i] >>> i);
					py_c[i+1] <= py_c[i] - (px_c[i] >>> i);
					pt_c[i+1] <= pt_c[i] + ATAN_TURN[i];
				end
			end
		end
	end

	// rounded Q30 products
	always_comb begin
		hp_prod = 57'(signed'({1'b0, cr_s1.range_value})) * 57'(cp_s1) + 57'(ROUND_HALF);
		zp_prod = 57'(signed'({1'b0, cr_s1.range_value})) * 57'(sp_s1) + 57'(ROUND_HALF);
		xp_prod = 59'(h_s2) * 59'(cy_s2) + 59'(ROUND_HALF);
		yp_prod = 59'(h_s2) * 59'(sy_s2) + 59'(ROUND_HALF);
	end

	// sign fix, scale by range, then by the horizontal length
	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s1 <= cr_c[CORDIC_STEPS];
			cy_s1 <= TRIG_W'(cr_c[CORDIC_STEPS].neg_yaw ? -yx_c[CORDIC_STEPS]
				: yx_c[CORDIC_STEPS]);
			sy_s1 <= TRIG_W'(cr_c[CORDIC_STEPS].neg_yaw ? -yy_c[CORDIC_STEPS]
				: yy_c[CORDIC_STEPS]);
			cp_s1 <= TRIG_W'(cr_c[CORDIC_STEPS].neg_pitch ? -px_c[CORDIC_STEPS]
				: px_c[CORDIC_STEPS]);
			sp_s1 <= TRIG_W'(cr_c[CORDIC_STEPS].neg_pitch ? -py_c[CORDIC_STEPS]
				: py_c[CORDIC_STEPS]);
			cr_s2 <= cr_s1;
			cy_s2 <= cy_s1;
			sy_s2 <= sy_s1;
			h_s2  <= H_W'(hp_prod >>> 30);
			z_s2  <= H_W'(zp_prod >>> 30);
			cr_s3 <= cr_s2;
			z_s3  <= z_s2;
			x_s3  <= XY_W'(xp_prod >>> 30);
			y_s3  <= XY_W'(yp_prod >>> 30);
			x_q    <= sat_coord(x_s3);
			y_q    <= sat_coord(y_s3);
			z_q    <= sat_coord(XY_W'(z_s3));
			str_q  <= cr_s3.strength;
			ring_q <= cr_s3.ring_number;
			time_q <= cr_s3.offset_time;
		end
	end

	// advance the valid bits along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CORDIC_STEPS; k++) v_c[k] <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_c[0] <= in_valid;
			for (int k = 0; k < CORDIC_STEPS; k++) v_c[k+1] <= v_c[k];
			v_s1        <= v_c[CORDIC_STEPS];
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign out_valid      = out_valid_q;
	assign point_x        = x_q;
	assign point_y        = y_q;
	assign point_z        = z_q;
	assign point_strength = str_q;
	assign ring_number    = ring_q;
	assign offset_time    = time_q;

endmodule

[hw/rtl/lidar_range_to_point.sv]
// Top level: lidar return to Cartesian point, with configuration registers.
//
//  channel  | direction | contents
//  s_axis   | in        | tdata: range_value, echo_strength, column_index, ring_index
//  m_axis   | out       | tdata: point_x, point_y, point_z, point_strength, ring_number,
//           |           |        offset_time
//  cfg      | in        | cfg_we, cfg_index, cfg_data register writes
//
// One item per clock sustained while m_axis is ready. Stages: one front stage, one
// queue stage, 25 CORDIC stages (24 micro-rotations plus load), three sign-fix and
// multiply stages and the output register; the 24-stage CORDIC pair sets the depth.
// Reset is asynchronous and clears control state only; registers take their defaults.
// A stall on m_axis freezes the back pipeline; the four-entry queue and the front
// stage keep taking items until full.
module lidar_range_to_point #(
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_RINGS   = 128,
	parameter int ANGLE_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// range_value[23:0], echo_strength[39:24], column_index[51:40], ring_index[58:52]
	input  logic [lrp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// point_x[24:0], point_y[49:25], point_z[74:50], point_strength[90:75],
	// ring_number[97:91], offset_time[129:98]
	output logic [lrp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [lrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lrp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lrp_pkg::*;

	cfg_t               cfg_q;
	logic               job_valid, job_ready;
	job_t               job;
	logic               q_valid, q_ready;
	job_t               q_job;
	logic [COORD_W-1:0] px, py, pz;
	logic [STR_W-1:0]   pstr;
	logic [RING_W-1:0]  pring;
	logic [TIME_W-1:0]  ptime;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_lo    <= '0;
			cfg_q.range_hi    <= '1;
			cfg_q.yaw_start   <= '0;
			cfg_q.yaw_step    <= '0;
			cfg_q.pitch_start <= '0;
			cfg_q.pitch_step  <= '0;
			cfg_q.ring_count  <= RCOUNT_W'(1);
			cfg_q.time_step   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RANGE_LO:    cfg_q.range_lo    <= cfg_data[RANGE_W-1:0];
				REG_RANGE_HI:    cfg_q.range_hi    <= cfg_data[RANGE_W-1:0];
				REG_YAW_START:   cfg_q.yaw_start   <= cfg_data[ANG_CFG_W-1:0];
				REG_YAW_STEP:    cfg_q.yaw_step    <= cfg_data[ANG_CFG_W-1:0];
				REG_PITCH_START: cfg_q.pitch_start <= cfg_data[ANG_CFG_W-1:0];
				REG_PITCH_STEP:  cfg_q.pitch_step  <= cfg_data[ANG_CFG_W-1:0];
				REG_RING_COUNT:  cfg_q.ring_count  <= cfg_data[RCOUNT_W-1:0];
				REG_TIME_STEP:   cfg_q.time_step   <= cfg_data[TSTEP_W-1:0];
				default: ;
			endcase
		end
	end

	lrp_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_RINGS  (MAX_RINGS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.range_value  (s_axis_tdata[23:0]),
		.echo_strength(s_axis_tdata[39:24]),
		.column_index (s_axis_tdata[51:40]),
		.ring_index   (s_axis_tdata[58:52]),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.job          (job)
	);

	lrp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(job_valid),
		.wr_ready(job_ready),
		.wr_job  (job),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_job  (q_job)
	);

	lrp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (q_valid),
		.in_ready      (q_ready),
		.job           (q_job),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.point_x       (px),
		.point_y       (py),
		.point_z       (pz),
		.point_strength(pstr),
		.ring_number   (pring),
		.offset_time   (ptime)
	);

	assign m_axis_tdata = {6'd0, ptime, pring, pstr, pz, py, px};

	// front holds its job while the queue is full
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job_ready) |=> (job_valid && $stable(job)))
		else $error("front dropped or changed a waiting job");

	// queue head stays put while the back is stalled
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !q_ready) |=> (q_valid && $stable(q_job)))
		else $error("queue head changed under a stall");

	// a waiting point freezes the back pipeline
	a_back_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !q_ready)
		else $error("back took a job while the output was stalled");

endmodule

[tb/sv/lidar_range_to_point_test.sv]
// Testbench for lidar_range_to_point: directed and random returns checked against a point predictor.
module lidar_range_to_point_test;
	import lrp_pkg::*;

	// packed from the top bit down, so x lands in the lowest bits of tdata
	typedef struct packed {
		logic [TIME_W-1:0]  offset;
		logic [RING_W-1:0]  ring;
		logic [STR_W-1:0]   strength;
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} point_t;

	localparam int  MAX_COLS   = 4096;
	localparam int  MAX_RINGS  = 128;
	localparam int  DRAIN_WAIT = 40;
	localparam longint ATAN_Q32 [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// register mirror
	logic [23:0]        gate_lo, gate_hi;
	logic signed [15:0] yaw0, yaw_inc, pitch0, pitch_inc;
	logic [7:0]         rings_cfg;
	logic [19:0]        ns_per_col;

	point_t pending_points[$];
	int     err_count;
	int     hold_request;
	bit     calm_sender;
	bit     calm_receiver;

	lidar_range_to_point u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	// binary angle to cosine and sine, Q30, by 24-step rotation
	function automatic void angle_trig(input logic [15:0] ang, output longint c,
			output longint s);
		longint t, x, y, nx;
		bit     neg;
		t = longint'($signed({ang, 16'h0000}));
		x = 652032874;
		y = 0;
		neg = 1'b0;
		if (t > (longint'(1) <<< 30)) begin
			t = t - (longint'(1) <<< 31);
			neg = 1'b1;
		end else if (t < -(longint'(1) <<< 30)) begin
			t = t + (longint'(1) <<< 31);
			neg = 1'b1;
		end
		for (int i = 0; i < 24; i++) begin
			if (t >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				t = t - ATAN_Q32[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				t = t + ATAN_Q32[i];
			end
			x = nx;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic longint scale_q30(input longint a, input longint b);
		return (a * b + (longint'(1) <<< 29)) >>> 30;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
		longint c;
		c = v;
		if (c > 16777215) c = 16777215;
		if (c < -16777216) c = -16777216;
		return c[COORD_W-1:0];
	endfunction

	// predict the point for one return; returns 0 when the return is dropped
	function automatic bit project_point(input logic [23:0] r, input logic [15:0] str,
			input logic [11:0] col, input logic [6:0] ring, output point_t p);
		int     count, yaw_a, pitch_a;
		longint cy, sy, cp, sp, h;
		count = (rings_cfg > MAX_RINGS) ? MAX_RINGS : int'(rings_cfg);
		p = '0;
		if (!(gate_lo < r && r < gate_hi)) return 0;
		if (int'(ring) >= count || int'(col) >= MAX_COLS) return 0;
		yaw_a = int'(yaw0) + int'(col) * int'(yaw_inc);
		pitch_a = int'(pitch0) + int'(ring) * int'(pitch_inc);
		angle_trig(yaw_a[15:0], cy, sy);
		angle_trig(pitch_a[15:0], cp, sp);
		h = scale_q30(longint'(r), cp);
		p.x = clamp_coord(scale_q30(h, cy));
		p.y = clamp_coord(scale_q30(h, sy));
		p.z = clamp_coord(scale_q30(longint'(r), sp));
		p.strength = str;
		p.ring = 7'(count - 1 - int'(ring));
		p.offset = 32'(longint'(col) * longint'(ns_per_col));
		return 1;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_RANGE_LO:    gate_lo = val;
			REG_RANGE_HI:    gate_hi = val;
			REG_YAW_START:   yaw0 = val[15:0];
			REG_YAW_STEP:    yaw_inc = val[15:0];
			REG_PITCH_START: pitch0 = val[15:0];
			REG_PITCH_STEP:  pitch_inc = val[15:0];
			REG_RING_COUNT:  rings_cfg = val[7:0];
			REG_TIME_STEP:   ns_per_col = val[19:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(input logic [23:0] lo, input logic [23:0] hi,
			input logic [15:0] ys, input logic [15:0] yi, input logic [15:0] ps,
			input logic [15:0] pi, input logic [7:0] rc, input logic [19:0] ts);
		write_reg(REG_RANGE_LO, lo);
		write_reg(REG_RANGE_HI, hi);
		write_reg(REG_YAW_START, 24'(ys));
		write_reg(REG_YAW_STEP, 24'(yi));
		write_reg(REG_PITCH_START, 24'(ps));
		write_reg(REG_PITCH_STEP, 24'(pi));
		write_reg(REG_RING_COUNT, 24'(rc));
		write_reg(REG_TIME_STEP, 24'(ts));
	endtask

	// offer one return and hold it until taken
	task automatic send_return(input logic [23:0] r, input logic [15:0] str,
			input logic [11:0] col, input logic [6:0] ring);
		int     gap;
		point_t p;
		gap = calm_sender ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {5'b0, ring, col, str, r};
		do @(posedge clk); while (!s_axis_tready);
		if (project_point(r, str, col, ring, p)) pending_points.push_back(p);
	endtask

	// lower valid, wait for every point, then let dropped items leave the pipe
	task automatic drain_points();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait (pending_points.size() == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic send_random(input int n);
		logic [23:0] r;
		logic [6:0]  ring;
		int          count;
		for (int i = 0; i < n; i++) begin
			count = (rings_cfg > MAX_RINGS) ? MAX_RINGS : int'(rings_cfg);
			if ($urandom_range(0, 9) < 8 && gate_hi > gate_lo + 1)
				r = 24'($urandom_range(int'(gate_lo) + 1, int'(gate_hi) - 1));
			else
				r = 24'($urandom);
			if ($urandom_range(0, 9) < 8 && count > 0)
				ring = 7'($urandom_range(0, count - 1));
			else
				ring = 7'($urandom);
			send_return(r, 16'($urandom), 12'($urandom), ring);
		end
	endtask

	// output check
	always @(posedge clk) begin
		point_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[129:0];
			if (pending_points.size() == 0) begin
				$error("point with none expected: %h", got);
				err_count++;
			end else begin
				want = pending_points.pop_front();
				if (got.x !== want.x) begin
					$error("point_x expected %h got %h", want.x, got.x);
					err_count++;
				end
				if (got.y !== want.y) begin
					$error("point_y expected %h got %h", want.y, got.y);
					err_count++;
				end
				if (got.z !== want.z) begin
					$error("point_z expected %h got %h", want.z, got.z);
					err_count++;
				end
				if (got.strength !== want.strength) begin
					$error("point_strength expected %h got %h", want.strength,
						got.strength);
					err_count++;
				end
				if (got.ring !== want.ring) begin
					$error("ring_number expected %0d got %0d", want.ring, got.ring);
					err_count++;
				end
				if (got.offset !== want.offset) begin
					$error("offset_time expected %0d got %0d", want.offset, got.offset);
					err_count++;
				end
			end
		end
	end

	// receiver: random stall per item, long hold-off on request
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				m_axis_tready = 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			gap = calm_receiver ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_axis_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic test_reset_gate();
		send_return(24'h000000, 16'h0000, 12'd0, 7'd0);
		send_return(24'hFFFFFF, 16'hFFFF, 12'd0, 7'd0);
		send_return(24'h000001, 16'hFFFF, 12'd0, 7'd0);
		send_return(24'hFFFFFE, 16'h0000, 12'd4095, 7'd0);
		send_return(24'h001000, 16'h1234, 12'd5, 7'd1);
		drain_points();
	endtask

	task automatic test_corners();
		// quarter-turn starts, saturation region, overflowing ring count
		write_all(24'd100, 24'd200, 16'h4000, 16'h0001, 16'hC000, 16'h0100,
			8'd200, 20'hFFFFF);
		send_return(24'd100, 16'h0001, 12'd0, 7'd0);
		send_return(24'd200, 16'h0001, 12'd0, 7'd0);
		send_return(24'd150, 16'hFFFF, 12'd4095, 7'd127);
		send_return(24'd101, 16'h8000, 12'd2048, 7'd64);
		drain_points();
		write_all(24'd0, 24'hFFFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
			8'd128, 20'd1);
		send_return(24'hFFFFFE, 16'hAAAA, 12'd0, 7'd0);
		send_return(24'hFFFFFE, 16'h5555, 12'd1, 7'd1);
		send_return(24'hFFFFFE, 16'h0F0F, 12'd4095, 7'd127);
		send_return(24'h800000, 16'hF0F0, 12'd3, 7'd126);
		drain_points();
		// empty gate, then no rings at all
		write_reg(REG_RANGE_LO, 24'd5000);
		write_reg(REG_RANGE_HI, 24'd5000);
		send_return(24'd5000, 16'h1111, 12'd1, 7'd0);
		send_return(24'd4999, 16'h1111, 12'd1, 7'd0);
		drain_points();
		write_all(24'd0, 24'hFFFFFF, 16'h2000, 16'hFFFF, 16'hE000, 16'h0010,
			8'd0, 20'd12345);
		send_return(24'd777, 16'h2222, 12'd9, 7'd0);
		drain_points();
		write_reg(REG_RING_COUNT, 24'd16);
		send_return(24'd777, 16'h2222, 12'd9, 7'd15);
		send_return(24'd777, 16'h2222, 12'd9, 7'd16);
		drain_points();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 14; ph++) begin
			calm_sender = ($urandom_range(0, 3) == 0);
			calm_receiver = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: write_all(24'd0, 24'hFFFFFF, 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 8'd128, 20'hFFFFF);
				1: write_all(24'($urandom_range(0, 4096)),
					24'($urandom_range(8192, 16777215)), 16'($urandom),
					16'($urandom_range(0, 64)), 16'($urandom),
					16'($urandom_range(0, 600)), 8'($urandom_range(1, 128)),
					20'($urandom));
				2: write_all(24'($urandom), 24'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
					20'($urandom));
				default: write_all(24'd0, 24'hFFFFFF, 16'd0, 16'd16, 16'hF000,
					16'd256, 8'd1, 20'd0);
			endcase
			send_random(100);
			drain_points();
		end
		calm_sender = 1'b0;
		calm_receiver = 1'b0;
	endtask

	task automatic test_backpressure();
		write_all(24'd0, 24'hFFFFFF, 16'h1000, 16'h0010, 16'hF800, 16'h0040,
			8'd32, 20'd100);
		hold_request = 300;
		calm_sender = 1'b1;
		send_random(80);
		calm_sender = 1'b0;
		// pause until every point is out, then resume
		drain_points();
		send_random(60);
		drain_points();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_RANGE_LO;
		cfg_data = '0;
		err_count = 0;
		hold_request = 0;
		calm_sender = 1'b0;
		calm_receiver = 1'b0;
		gate_lo = 24'd0;
		gate_hi = 24'hFFFFFF;
		yaw0 = '0;
		yaw_inc = '0;
		pitch0 = '0;
		pitch_inc = '0;
		rings_cfg = 8'd1;
		ns_per_col = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_reset_gate();
		test_corners();
		test_random_phases();
		test_backpressure();
		if (pending_points.size() != 0) begin
			$error("%0d points never arrived", pending_points.size());
			err_count++;
		end
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[lidar_range_to_point.f]
hw/rtl/lrp_pkg.sv
hw/rtl/lrp_front.sv
hw/rtl/lrp_fifo.sv
hw/rtl/lrp_back.sv
hw/rtl/lidar_range_to_point.sv
tb/sv/lidar_range_to_point_test.sv
